// ----- design/spn256_ctr_keystream_cipher_core_assert.svh -----
// assertion macros for the spn256 counter-mode keystream core
// used by the top level; needs only a clock and an active-high reset
`ifndef SPN256_CTR_KEYSTREAM_CIPHER_CORE_ASSERT_SVH
`define SPN256_CTR_KEYSTREAM_CIPHER_CORE_ASSERT_SVH

// same-cycle implication
`define SPN_ASSERT_IMPLY(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("spn256 core: assertion failed");

// next-cycle implication
`define SPN_ASSERT_NEXT(label, clk, rst, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("spn256 core: assertion failed");

`endif

// ----- design/spnctr_pkg.sv -----
// shared types, codes and the gf(2^8) multiply for the spn256 ctr core
// no dependencies
`default_nettype none

package spnctr_pkg;

  localparam int MIX_STRIDE = 32;
  localparam int IDX_W      = 5;
  localparam int RND_W      = 4;
  localparam int CFG_W      = 64;

  typedef enum logic [2:0] {
    TSEL_SBOX = 3'd0,
    TSEL_PERM = 3'd1,
    TSEL_RKEY = 3'd2,
    TSEL_FKEY = 3'd3,
    TSEL_MIX  = 3'd4
  } table_sel_t;

  typedef enum logic [1:0] {
    CFG_GF_POLY    = 2'd0,
    CFG_NONCE_HIGH = 2'd1,
    CFG_NONCE_LOW  = 2'd2
  } cfg_reg_t;

  // controller to datapath commands
  typedef struct packed {
    logic             busy;
    logic             load;
    logic             sub_go;
    logic             mix_go;
    logic             final_go;
    logic             emit;
    logic [IDX_W-1:0] idx;
    logic [RND_W-1:0] rnd;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic gen_start;
  } status_t;

  // shift-and-add multiply reduced by x^8 + poly
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] poly);
    logic [7:0] x;
    logic [7:0] acc;
    logic       carry;
    x   = a;
    acc = '0;
    for (int k = 0; k < 8; k++) begin
      if (b[k]) acc = acc ^ x;
      carry = x[7];
      x     = {x[6:0], 1'b0};
      if (carry) x = x ^ poly;
    end
    return acc;
  endfunction

endpackage

`default_nettype wire

// ----- design/spnctr_ram.sv -----
// generic simple dual-port ram with registered read
// no dependencies
`default_nettype none

module spnctr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- design/spnctr_ctrl.sv -----
// round sequencer for keystream block generation
// depends on spnctr_pkg
`default_nettype none

module spnctr_ctrl #(
  parameter int BLOCK_BYTES = 32,
  parameter int ROUND_COUNT = 5
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire spnctr_pkg::status_t st,
  output spnctr_pkg::cmd_t         cmd
);

  localparam int CW = $clog2(BLOCK_BYTES + 2);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_SUB,
    S_MIX,
    S_FIN,
    S_EMIT
  } state_t;

  state_t                        state;
  logic [CW-1:0]                 cnt;
  logic [spnctr_pkg::RND_W-1:0]  rnd;

  // state, byte counter and round counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      rnd   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (st.gen_start) state <= S_LOAD;
        end
        S_LOAD: begin
          state <= S_SUB;
          cnt   <= '0;
          rnd   <= '0;
        end
        S_SUB: begin
          if (cnt == CW'(BLOCK_BYTES + 1)) begin
            state <= S_MIX;
            cnt   <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_MIX: begin
          if (cnt == CW'(BLOCK_BYTES)) begin
            cnt <= '0;
            if (rnd == spnctr_pkg::RND_W'(ROUND_COUNT - 1)) begin
              state <= S_FIN;
            end else begin
              state <= S_SUB;
              rnd   <= rnd + 1'b1;
            end
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_FIN: begin
          state <= S_EMIT;
        end
        S_EMIT: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // command decode from the registered state
  always_comb begin
    cmd          = '0;
    cmd.busy     = (state != S_IDLE);
    cmd.load     = (state == S_LOAD);
    cmd.sub_go   = (state == S_SUB) && (cnt < CW'(BLOCK_BYTES));
    cmd.mix_go   = (state == S_MIX) && (cnt < CW'(BLOCK_BYTES));
    cmd.final_go = (state == S_FIN);
    cmd.emit     = (state == S_EMIT);
    cmd.idx      = spnctr_pkg::IDX_W'(cnt);
    cmd.rnd      = rnd;
  end

endmodule

`default_nettype wire

// ----- design/spnctr_dp.sv -----
// datapath: cipher tables, block state, keystream buffer and output register
// depends on spnctr_pkg and spnctr_ram
`default_nettype none

module spnctr_dp #(
  parameter int BLOCK_BYTES = 32,
  parameter int ROUND_COUNT = 5
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_write,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [spnctr_pkg::CFG_W-1:0] cfg_data,
  input  wire logic                         in_valid,
  input  wire logic                         in_stall,
  input  wire logic                         func,
  input  wire logic [2:0]                   table_select,
  input  wire logic [9:0]                   table_index,
  input  wire logic [7:0]                   table_value,
  input  wire logic [7:0]                   data_byte,
  input  wire logic                         message_start,
  input  wire logic                         message_last,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [7:0]                   out_byte,
  output logic                              out_last,
  input  wire spnctr_pkg::cmd_t             cmd,
  output spnctr_pkg::status_t               st
);

  localparam int IW   = $clog2(BLOCK_BYTES);
  localparam int RKD  = ROUND_COUNT * BLOCK_BYTES;
  localparam int RKW  = $clog2(RKD);
  localparam int NLEN = (BLOCK_BYTES - 8 > 16) ? 16 : BLOCK_BYTES - 8;

  logic [7:0]    gf_poly;
  logic [127:0]  nonce;
  logic [63:0]   ctr;
  logic [IW-1:0] pos;

  logic [7:0]    s     [BLOCK_BYTES];
  logic [7:0]    t     [BLOCK_BYTES];
  logic [7:0]    ks    [BLOCK_BYTES];
  logic [7:0]    fk    [BLOCK_BYTES];
  logic [IW-1:0] perm  [BLOCK_BYTES];
  logic [7:0]    col_q [BLOCK_BYTES];

  logic          acc, tw, dw;
  logic [4:0]    pm;
  logic [IW-1:0] p;
  logic [7:0]    sp;
  logic          v1, v2;
  logic [IW-1:0] i1, i2;
  logic          mv1;
  logic [IW-1:0] row1;
  logic [7:0]    mix_acc;
  logic [7:0]    rk_q, sbox_q;
  logic [RKW-1:0] rk_raddr;
  logic [7:0]    data_hold;
  logic          last_hold;

  assign acc = in_valid && !in_stall;
  assign tw  = acc && !func;
  assign dw  = acc && func;
  assign st.gen_start = dw && (message_start || pos == '0);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gf_poly <= 8'd27;
      nonce   <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        spnctr_pkg::CFG_GF_POLY:    gf_poly       <= cfg_data[7:0];
        spnctr_pkg::CFG_NONCE_HIGH: nonce[127:64] <= cfg_data;
        spnctr_pkg::CFG_NONCE_LOW:  nonce[63:0]   <= cfg_data;
        default: ;
      endcase
    end
  end

  // permutation entry reduced below the block size
  always_comb begin
    pm = table_value[4:0];
    for (int k = 0; k < 4; k++) begin
      if ({1'b0, pm} >= 6'(BLOCK_BYTES)) pm = 5'({1'b0, pm} - 6'(BLOCK_BYTES));
    end
  end

  // s-box and round key memories
  spnctr_ram #(.WIDTH(8), .DEPTH(256)) u_sbox (
    .clk   (clk),
    .we    (tw && table_select == spnctr_pkg::TSEL_SBOX && table_index[9:8] == 2'b00),
    .waddr (table_index[7:0]),
    .wdata (table_value),
    .raddr (sp ^ rk_q),
    .rdata (sbox_q)
  );

  spnctr_ram #(.WIDTH(8), .DEPTH(RKD)) u_rkey (
    .clk   (clk),
    .we    (tw && table_select == spnctr_pkg::TSEL_RKEY && table_index < 10'(RKD)),
    .waddr (table_index[RKW-1:0]),
    .wdata (table_value),
    .raddr (rk_raddr),
    .rdata (rk_q)
  );

  // substitution stage 0: permuted byte and round key address
  assign p        = perm[cmd.idx[IW-1:0]];
  assign rk_raddr = RKW'(32'(cmd.rnd) * BLOCK_BYTES + 32'(p));

  always_ff @(posedge clk) begin
    if (rst) begin
      v1  <= 1'b0;
      v2  <= 1'b0;
      mv1 <= 1'b0;
    end else begin
      v1  <= cmd.sub_go;
      v2  <= v1;
      mv1 <= cmd.mix_go;
    end
  end

  always_ff @(posedge clk) begin
    sp   <= s[p];
    i1   <= cmd.idx[IW-1:0];
    i2   <= i1;
    row1 <= cmd.idx[IW-1:0];
  end

  // one mix row per cycle over the column memories
  always_comb begin
    mix_acc = '0;
    for (int j = 0; j < BLOCK_BYTES; j++) begin
      mix_acc = mix_acc ^ spnctr_pkg::gf_mul(col_q[j], t[j], gf_poly);
    end
  end

  for (genvar i = 0; i < BLOCK_BYTES; i++) begin : g_byte
    // one memory per matrix column, addressed by row
    spnctr_ram #(.WIDTH(8), .DEPTH(spnctr_pkg::MIX_STRIDE)) u_col (
      .clk   (clk),
      .we    (tw && table_select == spnctr_pkg::TSEL_MIX && table_index[4:0] == 5'(i)),
      .waddr (table_index[9:5]),
      .wdata (table_value),
      .raddr (cmd.idx),
      .rdata (col_q[i])
    );

    // permutation and final key entries
    always_ff @(posedge clk) begin
      if (tw && table_index == 10'(i)) begin
        if (table_select == spnctr_pkg::TSEL_PERM) perm[i] <= pm[IW-1:0];
        if (table_select == spnctr_pkg::TSEL_FKEY) fk[i] <= table_value;
      end
    end

    // block state: counter block load and mix result
    always_ff @(posedge clk) begin
      if (cmd.load) begin
        if (i >= BLOCK_BYTES - 8) begin
          s[i] <= ctr[8*(BLOCK_BYTES-1-i) +: 8];
        end else if (i < NLEN) begin
          s[i] <= nonce[127-8*i -: 8];
        end else begin
          s[i] <= '0;
        end
      end else if (mv1 && row1 == IW'(i)) begin
        s[i] <= mix_acc;
      end
    end

    // substituted bytes
    always_ff @(posedge clk) begin
      if (v2 && i2 == IW'(i)) t[i] <= sbox_q;
    end

    // keystream buffer after final whitening
    always_ff @(posedge clk) begin
      if (rst) begin
        ks[i] <= '0;
      end else if (cmd.final_go) begin
        ks[i] <= s[i] ^ fk[i];
      end
    end
  end

  // counter, byte position and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ctr       <= '0;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.emit || (dw && !st.gen_start)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.final_go) ctr <= ctr + 64'd1;
      if (dw) begin
        if (message_start) ctr <= '0;
        if (!st.gen_start) begin
          pos <= (pos == IW'(BLOCK_BYTES - 1)) ? '0 : pos + 1'b1;
        end else begin
          pos <= '0;
        end
      end
      if (cmd.emit) begin
        pos <= IW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dw) begin
      data_hold <= data_byte;
      last_hold <= message_last;
      out_byte  <= data_byte ^ ks[pos];
      out_last  <= message_last;
    end
    if (cmd.emit) begin
      out_byte <= data_hold ^ ks[0];
      out_last <= last_hold;
    end
  end

endmodule

`default_nettype wire

// ----- design/spn256_ctr_keystream_cipher_core.sv -----
// spn256 counter-mode keystream cipher core
//
// Channels: input items (func, table_select, table_index, table_value,
// data_byte, message_start, message_last) on in_valid/in_stall; results
// (out_byte, out_last) on out_valid/out_stall. A transaction completes on
// a rising edge with valid high and stall low. Config writes use
// cfg_write/cfg_index/cfg_data, and the user must see that they are taken
// only while the core is idle; the core does not enforce this. Table
// writes give no result. A data byte inside the current keystream block
// gives its registered result in the cycle after acceptance. A data byte
// at a block boundary (or with message_start) first builds a new block:
// a load, ROUND_COUNT rounds through the permute/key/s-box pipe plus a
// matrix mix of one row per cycle, then whitening and the emit of the
// pending byte. Reset clears the counter, byte position, keystream and
// nonce and sets gf_poly to 27; the cipher tables hold garbage until
// written. While a result waits under out_stall, in_stall stays high.
// depends on spnctr_pkg, spnctr_ctrl, spnctr_dp and the assertion header
`default_nettype none

`include "spn256_ctr_keystream_cipher_core_assert.svh"

module spn256_ctr_keystream_cipher_core #(
  parameter int BLOCK_BYTES = 32,
  parameter int ROUND_COUNT = 5
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_write,
  input  wire logic [1:0]                   cfg_index,
  input  wire logic [spnctr_pkg::CFG_W-1:0] cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         func,
  input  wire logic [2:0]                   table_select,
  input  wire logic [9:0]                   table_index,
  input  wire logic [7:0]                   table_value,
  input  wire logic [7:0]                   data_byte,
  input  wire logic                         message_start,
  input  wire logic                         message_last,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic      [7:0]                   out_byte,
  output logic                              out_last
);

  spnctr_pkg::cmd_t    cmd;
  spnctr_pkg::status_t st;

  // hold input while generating or while a result is stuck
  assign in_stall = cmd.busy || (out_valid && out_stall);

  spnctr_ctrl #(.BLOCK_BYTES(BLOCK_BYTES), .ROUND_COUNT(ROUND_COUNT)) u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  spnctr_dp #(.BLOCK_BYTES(BLOCK_BYTES), .ROUND_COUNT(ROUND_COUNT)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .func          (func),
    .table_select  (table_select),
    .table_index   (table_index),
    .table_value   (table_value),
    .data_byte     (data_byte),
    .message_start (message_start),
    .message_last  (message_last),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_byte      (out_byte),
    .out_last      (out_last),
    .cmd           (cmd),
    .st            (st)
  );

  // block generation starts right after the triggering byte
  `SPN_ASSERT_NEXT(a_gen_busy, clk, rst, st.gen_start, cmd.busy)
  // output register is free while a block is being built
  `SPN_ASSERT_NEXT(a_gen_out_free, clk, rst, st.gen_start, !out_valid)
  // whitening is followed by the emit of the pending byte
  `SPN_ASSERT_NEXT(a_fin_emit, clk, rst, cmd.final_go, cmd.emit && out_valid == 1'b0)

endmodule

`default_nettype wire
